[sv/point_in_region_prism_core_defines.svh]
// Assertion macros shared by the point-in-region prism core.
`ifndef POINT_IN_REGION_PRISM_CORE_DEFINES_SVH
`define POINT_IN_REGION_PRISM_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PIRP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pirp assertion failed");
`define PIRP_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pirp assertion failed");
`else
`define PIRP_ASSERT(lbl, prop)
`define PIRP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[sv/pirp_pkg.sv]
// Types, constants and helpers for the point-in-region prism core.
package pirp_pkg;

    localparam int MAX_NODES = 16;
    localparam int NODE_AW   = $clog2(MAX_NODES);
    localparam int PROD_W    = 33;
    localparam int ACC_W     = 35;
    localparam int HGT_W     = 19;

    typedef logic [2:0] t_cfg_addr;
    localparam t_cfg_addr CFG_BOX_MIN      = 3'd0;
    localparam t_cfg_addr CFG_BOX_MAX      = 3'd1;
    localparam t_cfg_addr CFG_FLOOR_NORMAL = 3'd2;
    localparam t_cfg_addr CFG_REGION_HGT   = 3'd3;
    localparam t_cfg_addr CFG_NODE_COUNT   = 3'd4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // what a dot product pass belongs to
    typedef logic [1:0] t_tag;
    localparam t_tag TAG_NODE  = 2'd0;
    localparam t_tag TAG_FLOOR = 2'd1;
    localparam t_tag TAG_CEIL  = 2'd2;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        t_tag tag;
    } t_mac_ctl;

    typedef struct packed {
        logic done;
        t_tag tag;
    } t_mac_sts;

    localparam logic [HGT_W-1:0] HGT_MAX = 19'h3FFFF;
    localparam logic [HGT_W-1:0] HGT_MIN = 19'h40000;

    function automatic logic signed [15:0] lane16(input logic [47:0] w, input logic [1:0] k);
        logic signed [15:0] v;
        case (k)
            2'd0:    v = w[15:0];
            2'd1:    v = w[31:16];
            default: v = w[47:32];
        endcase
        return v;
    endfunction

endpackage

[sv/pirp_mac.sv]
// Shared multiply-accumulate unit: acc += (a - b) * n, one lane per beat.
module pirp_mac (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  pirp_pkg::t_mac_ctl                  i_ctl,
    input  logic signed [15:0]                  i_a,
    input  logic signed [15:0]                  i_b,
    input  logic signed [15:0]                  i_n,
    output logic signed [pirp_pkg::ACC_W-1:0]   o_acc,
    output pirp_pkg::t_mac_sts                  o_sts
);
    import pirp_pkg::*;

    logic signed [16:0]       w_diff;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  w_base;
    logic signed [ACC_W-1:0]  r_acc;
    t_mac_ctl                 r_s1;
    t_mac_sts                 r_sts;

    assign w_diff = 17'(i_a) - 17'(i_b);
    assign w_prod = w_diff * i_n;
    assign w_base = r_s1.first ? '0 : r_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_sts <= '0;
        end else begin
            r_s1      <= i_ctl;
            r_sts.done <= r_s1.valid & r_s1.last;
            r_sts.tag  <= r_s1.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prod <= w_prod;
        end
        if (r_s1.valid) begin
            r_acc <= w_base + ACC_W'(r_prod);
        end
    end

    assign o_acc = r_acc;
    assign o_sts = r_sts;

endmodule

[sv/pirp_node_store.sv]
// Corner node memory: position and edge normal per slot, registered read.
module pirp_node_store (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [pirp_pkg::NODE_AW-1:0]  i_waddr,
    input  logic [95:0]                   i_wdata,
    input  logic                          i_re,
    input  logic [pirp_pkg::NODE_AW-1:0]  i_raddr,
    output logic [95:0]                   o_rdata
);
    import pirp_pkg::*;

    logic [95:0] r_mem [MAX_NODES];
    logic [95:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[sv/point_in_region_prism_core.sv]
// Top level: point-in-convex-prism test against stored corner nodes.
//
// Node write beats (tuser = 0) store one corner node each. A query beat
// (tuser = 1) runs the point through one shared multiply-accumulate unit,
// one coordinate lane per cycle: three lanes for the edge plane of each node
// in use, three for the floor plane through node 0 and one for the ceiling
// term. No new beat is taken until the query is through; a query with no
// nodes returns outside. The result sits in an output register, so the next
// beat can be taken while it waits. Configuration is to be written only while
// the core is idle; the core itself does not enforce this.
module point_in_region_prism_core (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // config write port
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [47:0]  i_cfg_wdata,
    // input stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [3:0] node_index, [19:4] pos_x, [35:20] pos_y, [51:36] pos_z,
    // [67:52] edge_nx, [83:68] edge_ny, [99:84] edge_nz, [103:100] zero
    input  logic [103:0] i_s_tdata,
    // [0] cmd
    input  logic         i_s_tuser,
    // output stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [18:0] floor_height, [23:19] zero
    output logic [23:0]  o_m_tdata,
    // [0] inside_res
    output logic         o_m_tuser
);
    import pirp_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_PUT   = 2'd3;

    logic [47:0]              r_box_min;
    logic [47:0]              r_box_max;
    logic [47:0]              r_floor_normal;
    logic [14:0]              r_region_hgt;
    logic [4:0]               r_node_count;

    logic [1:0]               r_state;
    logic [1:0]               n_state;
    logic [47:0]              r_pt;
    logic [NODE_AW-1:0]       r_cnt_m1;
    logic [NODE_AW-1:0]       r_node;
    logic [1:0]               r_lane;
    t_tag                     r_phase;
    logic                     r_inside;
    logic signed [ACC_W-1:0]  r_d;
    logic [HGT_W-1:0]         r_height;

    logic                     r_out_valid;
    logic                     r_out_inside;
    logic [HGT_W-1:0]         r_out_height;

    logic                     w_s_acc;
    logic                     w_query;
    logic [47:0]              w_in_pos;
    logic [47:0]              w_in_nrm;
    logic [NODE_AW-1:0]       w_in_idx;
    logic [4:0]               w_cnt;
    logic                     w_box_ok;
    logic                     w_we;
    logic                     w_re;
    logic [NODE_AW-1:0]       w_raddr;
    logic [95:0]              w_rdata;
    logic                     w_lane_end;
    logic                     w_last_node;
    logic                     w_out_free;
    t_mac_ctl                 w_ctl;
    logic signed [15:0]       w_a;
    logic signed [15:0]       w_b;
    logic signed [15:0]       w_n;
    logic signed [ACC_W-1:0]  w_acc;
    t_mac_sts                 w_sts;
    logic signed [ACC_W:0]    w_v;
    logic [ACC_W-14:0]        w_q;
    logic [HGT_W-1:0]         w_hsat;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_s_acc    = i_s_tvalid & o_s_tready;
    assign w_query    = (i_s_tuser == CMD_QUERY);
    assign w_in_idx   = i_s_tdata[3:0];
    assign w_in_pos   = i_s_tdata[51:4];
    assign w_in_nrm   = i_s_tdata[99:52];
    assign w_cnt      = (r_node_count > 5'(MAX_NODES)) ? 5'(MAX_NODES) : r_node_count;
    assign w_we       = w_s_acc & ~w_query & (32'(w_in_idx) < MAX_NODES);
    assign w_out_free = ~r_out_valid | i_m_tready;

    always_comb begin
        w_box_ok = 1'b1;
        for (int k = 0; k < 3; k++) begin
            if (lane16(w_in_pos, 2'(k)) < lane16(r_box_min, 2'(k)) ||
                lane16(w_in_pos, 2'(k)) > lane16(r_box_max, 2'(k))) begin
                w_box_ok = 1'b0;
            end
        end
    end

    // operand selection and node fetch
    assign w_lane_end  = (r_lane == 2'd2);
    assign w_last_node = (r_node == r_cnt_m1);

    always_comb begin
        w_ctl       = '0;
        w_ctl.tag   = r_phase;
        w_ctl.first = (r_lane == 2'd0);
        w_ctl.last  = w_lane_end;
        w_a         = lane16(r_pt, r_lane);
        w_b         = lane16(w_rdata[47:0], r_lane);
        w_n         = lane16(w_rdata[95:48], r_lane);
        w_re        = 1'b0;
        w_raddr     = '0;
        if (w_s_acc && w_query) begin
            w_re = 1'b1;
        end
        if (r_state == S_RUN) begin
            w_ctl.valid = 1'b1;
            case (r_phase)
                TAG_NODE: begin
                    if (w_lane_end) begin
                        w_re    = 1'b1;
                        w_raddr = w_last_node ? '0 : r_node + 1'b1;
                    end
                end
                TAG_FLOOR: begin
                    w_n = lane16(r_floor_normal, r_lane);
                end
                default: begin
                    w_ctl.first = 1'b1;
                    w_ctl.last  = 1'b1;
                    w_a         = signed'({1'b0, r_region_hgt});
                    w_b         = '0;
                    w_n         = lane16(r_floor_normal, 2'd2);
                end
            endcase
        end
    end

    pirp_node_store u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_in_idx),
        .i_wdata ({w_in_nrm, w_in_pos}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    pirp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_n     (w_n),
        .o_acc   (w_acc),
        .o_sts   (w_sts)
    );

    // floor height: round half up, then saturate
    assign w_v    = (ACC_W+1)'(w_acc) + (ACC_W+1)'(8192);
    assign w_q    = w_v[ACC_W:14];
    assign w_hsat = ((&w_q[ACC_W-14:HGT_W-1]) || !(|w_q[ACC_W-14:HGT_W-1])) ?
                    w_q[HGT_W-1:0] : (w_q[ACC_W-14] ? HGT_MIN : HGT_MAX);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_s_acc && w_query) begin
                    n_state = (w_cnt == 5'd0) ? S_PUT : S_RUN;
                end
            end
            S_RUN: begin
                if (r_phase == TAG_CEIL) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (w_sts.done && w_sts.tag == TAG_CEIL) begin
                    n_state = S_PUT;
                end
            end
            default: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_min      <= '0;
            r_box_max      <= '0;
            r_floor_normal <= '0;
            r_region_hgt   <= '0;
            r_node_count   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BOX_MIN:      r_box_min      <= i_cfg_wdata;
                CFG_BOX_MAX:      r_box_max      <= i_cfg_wdata;
                CFG_FLOOR_NORMAL: r_floor_normal <= i_cfg_wdata;
                CFG_REGION_HGT:   r_region_hgt   <= i_cfg_wdata[14:0];
                CFG_NODE_COUNT:   r_node_count   <= i_cfg_wdata[4:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_lane      <= '0;
            r_node      <= '0;
            r_phase     <= TAG_NODE;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_PUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end
            if (w_s_acc && w_query) begin
                r_lane  <= '0;
                r_node  <= '0;
                r_phase <= TAG_NODE;
            end
            if (r_state == S_RUN) begin
                r_lane <= w_lane_end ? 2'd0 : r_lane + 2'd1;
                if (w_lane_end) begin
                    case (r_phase)
                        TAG_NODE: begin
                            if (w_last_node) begin
                                r_phase <= TAG_FLOOR;
                            end else begin
                                r_node <= r_node + 1'b1;
                            end
                        end
                        TAG_FLOOR: r_phase <= TAG_CEIL;
                        default: begin
                        end
                    endcase
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc && w_query) begin
            r_pt     <= w_in_pos;
            r_cnt_m1 <= NODE_AW'(w_cnt - 5'd1);
            r_inside <= (w_cnt != 5'd0) & w_box_ok;
            r_height <= '0;
        end
        if (w_sts.done) begin
            case (w_sts.tag)
                TAG_NODE: begin
                    if (w_acc < 0) begin
                        r_inside <= 1'b0;
                    end
                end
                TAG_FLOOR: begin
                    r_d      <= w_acc;
                    r_height <= w_hsat;
                    if (w_acc < 0) begin
                        r_inside <= 1'b0;
                    end
                end
                default: begin
                    if (r_d > w_acc) begin
                        r_inside <= 1'b0;
                    end
                end
            endcase
        end
        if (r_state == S_PUT && w_out_free) begin
            r_out_inside <= r_inside;
            r_out_height <= r_height;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_inside;
    assign o_m_tdata  = {5'd0, r_out_height};

`include "point_in_region_prism_core_defines.svh"

    `PIRP_ASSERT(a_no_done_when_idle, (r_state == S_IDLE || r_state == S_PUT) |-> !w_sts.done)
    `PIRP_ASSERT(a_ceil_ends_run, (r_state == S_RUN && r_phase == TAG_CEIL) |=> r_state == S_DRAIN)
    `PIRP_ASSERT(a_ceil_done_in_drain, (w_sts.done && w_sts.tag == TAG_CEIL) |-> r_state == S_DRAIN)
    `PIRP_ASSERT_ALWAYS(a_no_rw_clash, w_we |-> !w_re)

endmodule

[sim/point_in_region_prism_checker.sv]
// Checker for the point-in-region prism core: mirrors its state and scores every result beat.
module point_in_region_prism_checker
    import pirp_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [47:0]  i_cfg_wdata,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    // [3:0] node_index, [51:4] pos x/y/z, [99:52] edge normal x/y/z, [103:100] zero
    input  logic [103:0] i_s_tdata,
    // [0] cmd
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    // [18:0] floor_height, [23:19] zero
    input  logic [23:0]  i_m_tdata,
    // [0] inside_res
    input  logic         i_m_tuser,
    output int           o_fail_count,
    output int           o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic               in_region;
        logic signed [18:0] height;
    } t_verdict;

    logic [47:0] box_lo, box_hi, floor_nrm;
    logic [14:0] rheight;
    logic [4:0]  node_cnt;
    logic [47:0] node_pos [MAX_NODES];
    logic [47:0] node_nrm [MAX_NODES];
    t_verdict    verdict_q [$];
    int          fails;

    function automatic longint coord(input logic [47:0] w, input int k);
        return longint'($signed(w[16*k +: 16]));
    endfunction

    // (p - q) . n, Q11.4 times Q1.14, exact
    function automatic longint plane_dist(input logic [47:0] p, q, n);
        longint acc;
        acc = 0;
        for (int k = 0; k < 3; k++)
            acc += (coord(p, k) - coord(q, k)) * coord(n, k);
        return acc;
    endfunction

    function automatic t_verdict region_verdict(input logic [47:0] pt);
        t_verdict r;
        longint   d, v;
        int       cnt;
        logic     ok;
        cnt = (node_cnt > MAX_NODES) ? MAX_NODES : int'(node_cnt);
        if (cnt == 0)
            return '0;
        ok = 1'b1;
        for (int a = 0; a < 3; a++)
            if (coord(pt, a) < coord(box_lo, a) || coord(pt, a) > coord(box_hi, a))
                ok = 1'b0;
        for (int n = 0; n < cnt; n++)
            if (plane_dist(pt, node_pos[n], node_nrm[n]) < 0)
                ok = 1'b0;
        d = plane_dist(pt, node_pos[0], floor_nrm);
        if (d < 0)
            ok = 1'b0;
        if (d - longint'(rheight) * coord(floor_nrm, 2) > 0)
            ok = 1'b0;
        // round half up, then clamp to 19 bits
        v = (d + 8192) >>> 14;
        if (v > 262143)
            v = 262143;
        if (v < -262144)
            v = -262144;
        r.in_region = ok;
        r.height    = v[18:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            box_lo    = '0;
            box_hi    = '0;
            floor_nrm = '0;
            rheight   = '0;
            node_cnt  = '0;
            for (int n = 0; n < MAX_NODES; n++) begin
                node_pos[n] = '0;
                node_nrm[n] = '0;
            end
            verdict_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_BOX_MIN:      box_lo    = i_cfg_wdata;
                    CFG_BOX_MAX:      box_hi    = i_cfg_wdata;
                    CFG_FLOOR_NORMAL: floor_nrm = i_cfg_wdata;
                    CFG_REGION_HGT:   rheight   = i_cfg_wdata[14:0];
                    CFG_NODE_COUNT:   node_cnt  = i_cfg_wdata[4:0];
                    default: ;
                endcase
            end
            // result beat first: it can never belong to a query taken at this edge
            if (i_m_tvalid && i_m_tready) begin
                if (verdict_q.size() == 0) begin
                    $error("result beat with no query outstanding");
                    fails++;
                end else begin
                    want = verdict_q.pop_front();
                    if (i_m_tuser !== want.in_region) begin
                        $error("inside_res: expected %0d, got %0d", want.in_region, i_m_tuser);
                        fails++;
                    end
                    if (i_m_tdata[18:0] !== want.height) begin
                        $error("floor_height: expected %0d, got %0d",
                               want.height, $signed(i_m_tdata[18:0]));
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == CMD_WRITE) begin
                    node_pos[i_s_tdata[3:0]] = i_s_tdata[51:4];
                    node_nrm[i_s_tdata[3:0]] = i_s_tdata[99:52];
                end else begin
                    verdict_q.insert(verdict_q.size(), region_verdict(i_s_tdata[51:4]));
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= verdict_q.size();
    end

endmodule

[sim/point_in_region_prism_core_test.sv]
// Testbench top for the point-in-region prism core: clock, reset, stimulus and verdict.
module point_in_region_prism_core_test;
    import pirp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_cfg_we    = 1'b0;
    logic [2:0]   i_cfg_addr  = '0;
    logic [47:0]  i_cfg_wdata = '0;
    logic         i_s_tvalid  = 1'b0;
    logic         o_s_tready;
    logic [103:0] i_s_tdata   = '0;
    logic         i_s_tuser   = 1'b0;
    logic         o_m_tvalid;
    logic         i_m_tready  = 1'b0;
    logic [23:0]  o_m_tdata;
    logic         o_m_tuser;

    int fail_count;
    int pending;
    bit tx_idle_on = 1'b1;
    bit hold_req   = 1'b0;

    // inward unit normals of an octagon, Q1.14
    int dir_x [8] = '{16384, 11585, 0, -11585, -16384, -11585, 0, 11585};
    int dir_y [8] = '{0, 11585, 16384, 11585, 0, -11585, -16384, -11585};

    point_in_region_prism_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );

    point_in_region_prism_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [15:0] sat16(input int v);
        return (v > 32767) ? 16'h7fff : (v < -32768) ? 16'h8000 : 16'(v);
    endfunction

    function automatic logic [47:0] pack3(input int x, y, z);
        return {sat16(z), sat16(y), sat16(x)};
    endfunction

    function automatic int jitter(input int span);
        return int'($urandom_range(2 * span, 0)) - span;
    endfunction

    task automatic send_beat(input logic cmd, input logic [3:0] idx,
                             input logic [47:0] pos, input logic [47:0] nrm);
        int gap;
        gap = tx_idle_on ? $urandom_range(10, 0) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= cmd;
        i_s_tdata  <= {4'b0, nrm, pos, idx};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // ignored fields of a query carry noise
    task automatic query_at(input int x, y, z);
        send_beat(CMD_QUERY, 4'($urandom), pack3(x, y, z), 48'({$urandom(), $urandom()}));
    endtask

    task automatic settle;
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (64) @(posedge i_clk);
    endtask

    task automatic reg_write(input t_cfg_addr a, input logic [47:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= a;
        i_cfg_wdata <= d;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [47:0] lo, hi, fn, input int hgt, cnt);
        settle();
        reg_write(CFG_BOX_MIN, lo);
        reg_write(CFG_BOX_MAX, hi);
        reg_write(CFG_FLOOR_NORMAL, fn);
        reg_write(CFG_REGION_HGT, 48'(hgt));
        reg_write(CFG_NODE_COUNT, 48'(cnt));
        i_cfg_we <= 1'b0;
    endtask

    // all slots get a node; consecutive nodes step 3/8 turn so any 3 consecutive nodes bound a region
    task automatic load_polygon(input int cx, cy, z0, rad);
        int d;
        for (int n = 0; n < MAX_NODES; n++) begin
            d = (n * 3) % 8;
            send_beat(CMD_WRITE, 4'(n),
                      pack3(cx - rad * dir_x[d] / 16384, cy - rad * dir_y[d] / 16384, z0),
                      pack3(dir_x[d], dir_y[d], 0));
        end
    endtask

    initial begin : result_sink
        int  wait_n;
        int  beats;
        bit  idle_on;
        beats   = 0;
        idle_on = 1'b1;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (beats % 40 == 0)
                idle_on = ($urandom_range(3, 0) != 0);
            wait_n = idle_on ? $urandom_range(10, 0) : 0;
            if (hold_req) begin
                wait_n   = 300;
                hold_req = 1'b0;
            end
            if (wait_n > 0) begin
                i_m_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
            beats++;
        end
    end

    initial begin : stimulus
        int          cx, cy, z0, rad, hgt, cnt, m, ax, tmp, r;
        int          lo3 [3];
        int          hi3 [3];
        logic [47:0] fnrm;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no nodes in use after reset
        query_at(0, 0, 0);
        query_at(32767, -32768, 32767);

        configure(pack3(-1600, -1600, 0), pack3(1600, 1600, 1600), pack3(0, 0, 16384), 1600, 8);
        load_polygon(0, 0, 0, 1600);
        query_at(0, 0, 800);
        query_at(-1600, 0, 800);    // on edge plane and box face
        query_at(-1601, 0, 800);
        query_at(0, 0, 0);          // on floor
        query_at(0, 0, -1);
        query_at(0, 0, 1600);       // on ceiling
        query_at(0, 0, 1601);

        // count above table size
        configure(pack3(-1600, -1600, 0), pack3(1600, 1600, 1600), pack3(0, 0, 16384), 1600, 31);
        query_at(0, 0, 800);

        // inverted box on x
        configure(pack3(1601, -1600, 0), pack3(1600, 1600, 1600), pack3(0, 0, 16384), 1600, 8);
        query_at(0, 0, 800);

        // floor height saturation, both ends
        configure(pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
                  pack3(32767, 32767, 32767), 32767, 1);
        send_beat(CMD_WRITE, 4'd0, pack3(-32768, -32768, -32768), pack3(16384, 16384, 16384));
        query_at(32767, 32767, 32767);
        configure(pack3(-32768, -32768, -32768), pack3(32767, 32767, 32767),
                  pack3(-32768, -32768, -32768), 0, 1);
        query_at(32767, 32767, 32767);
        query_at(-32768, -32768, -32768);

        for (int set = 0; set < 13; set++) begin
            cx  = jitter(12000);
            cy  = jitter(12000);
            z0  = jitter(8000);
            rad = $urandom_range(8000, 64);
            r   = $urandom_range(9, 0);
            hgt = (r == 0) ? 0 : (r == 1) ? 32767 : $urandom_range(4000, 16);
            r   = $urandom_range(9, 0);
            cnt = (r == 0) ? 0 : (r == 1) ? $urandom_range(31, 17) :
                  (r == 2) ? MAX_NODES : $urandom_range(8, 3);
            fnrm = ($urandom_range(2, 0) == 0) ? pack3(jitter(3000), jitter(3000), 16000)
                                                : pack3(0, 0, 16384);
            m = $urandom_range(5, 0);
            lo3 = '{cx - rad + jitter(rad / 8), cy - rad + jitter(rad / 8), z0 + jitter(16)};
            hi3 = '{cx + rad + jitter(rad / 8), cy + rad + jitter(rad / 8),
                    z0 + hgt + jitter(16)};
            if (m == 0) begin
                lo3 = '{-32768, -32768, -32768};
                hi3 = '{32767, 32767, 32767};
            end else if (m == 5) begin
                ax      = $urandom_range(2, 0);
                tmp     = lo3[ax];
                lo3[ax] = hi3[ax] + 1;
                hi3[ax] = tmp;
            end
            configure(pack3(lo3[0], lo3[1], lo3[2]), pack3(hi3[0], hi3[1], hi3[2]),
                      fnrm, hgt, cnt);
            tx_idle_on = ($urandom_range(3, 0) != 0);
            load_polygon(cx, cy, z0, rad);
            if (set == 2)
                hold_req = 1'b1;
            repeat (30) begin
                r = $urandom_range(19, 0);
                if (r == 0)
                    send_beat(CMD_WRITE, 4'($urandom),
                              48'({$urandom(), $urandom()}),
                              pack3(jitter(16384), jitter(16384), jitter(16384)));
                else if (r < 4)
                    query_at(jitter(32768), jitter(32768), jitter(32768));
                else
                    query_at(cx + jitter(rad + rad / 4), cy + jitter(rad + rad / 4),
                             z0 + hgt / 2 + jitter(hgt / 2 + hgt / 4 + 16));
            end
        end

        settle();
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+sv
sv/pirp_pkg.sv
sv/pirp_mac.sv
sv/pirp_node_store.sv
sv/point_in_region_prism_core.sv
sim/point_in_region_prism_checker.sv
sim/point_in_region_prism_core_test.sv
